// File: rtl/core/dfir_pkg.sv
// ----------------------------------------------------------------------------
// dfir_pkg
// Shared constants and types for the direct-form FIR filter core.
// ----------------------------------------------------------------------------
package dfir_pkg;

   localparam int DEF_MAX_TAPS    = 32;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int COEF_W      = 16;
   localparam int OUT_W       = 37;
   localparam int INDEX_W     = 5;
   localparam int TAP_COUNT_W = 6;
   localparam int GROUP_SIZE  = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_SEL_W  = CSR_ADDR_W - 2;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [CSR_SEL_W-1:0] REG_TAP_COUNT = 1'b0;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 6'd1;

   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctrl_type;

endpackage

// File: rtl/core/dfir_csr.sv
// ----------------------------------------------------------------------------
// dfir_csr
// Register port holding the tap count; yields the effective tap count.
// ----------------------------------------------------------------------------
module dfir_csr #(
   parameter int MAX_TAPS = dfir_pkg::DEF_MAX_TAPS,
   parameter int CNT_W    = $clog2(MAX_TAPS + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dfir_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dfir_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dfir_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output logic [CNT_W-1:0]                eff_taps
);
   import dfir_pkg::*;

   logic [TAP_COUNT_W-1:0] tap_count_ff;
   logic [CSR_SEL_W-1:0]   reg_sel;
   logic                   write_en;

   assign reg_sel    = csr_paddr[CSR_ADDR_W-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
      end else if (write_en && reg_sel == REG_TAP_COUNT) begin
         tap_count_ff <= csr_pwdata[TAP_COUNT_W-1:0];
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_TAP_COUNT: csr_prdata = CSR_DATA_W'(tap_count_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // clamp: zero acts as one, oversize acts as the build maximum
   always_comb begin
      if (tap_count_ff == '0) begin
         eff_taps = CNT_W'(1);
      end else if (int'(tap_count_ff) > MAX_TAPS) begin
         eff_taps = CNT_W'(MAX_TAPS);
      end else begin
         eff_taps = CNT_W'(tap_count_ff);
      end
   end

endmodule

// File: rtl/core/dfir_mac_stage.sv
// ----------------------------------------------------------------------------
// dfir_mac_stage
// Delay line, tap store, frame fill count and the registered product row.
// ----------------------------------------------------------------------------
module dfir_mac_stage #(
   parameter int MAX_TAPS    = dfir_pkg::DEF_MAX_TAPS,
   parameter int SAMPLE_BITS = dfir_pkg::DEF_SAMPLE_BITS,
   parameter int CNT_W       = $clog2(MAX_TAPS + 1),
   parameter int PROD_W      = SAMPLE_BITS + dfir_pkg::COEF_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                load_accept,
   input  logic                                sample_accept,
   input  logic [dfir_pkg::INDEX_W-1:0]        tap_index,
   input  logic signed [dfir_pkg::COEF_W-1:0]  coefficient,
   input  logic signed [SAMPLE_BITS-1:0]       sample,
   input  logic                                frame_last,
   input  logic [CNT_W-1:0]                    eff_taps,
   output dfir_pkg::stage_ctrl_type            s1_ctrl,
   output logic [CNT_W-1:0]                    s1_taps,
   output logic signed [PROD_W-1:0]            s1_prod [MAX_TAPS]
);
   import dfir_pkg::*;

   logic signed [SAMPLE_BITS-1:0] hist_ff [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_in [MAX_TAPS];
   logic signed [COEF_W-1:0]      taps_ff [MAX_TAPS];
   logic signed [PROD_W-1:0]      prod_in [MAX_TAPS];
   logic [CNT_W-1:0]              fill_ff;
   logic [CNT_W-1:0]              fill_in;
   stage_ctrl_type                s1_ctrl_ff;
   logic [CNT_W-1:0]              s1_taps_ff;
   logic signed [PROD_W-1:0]      s1_prod_ff [MAX_TAPS];

   always_comb begin
      hist_in[0] = sample;
      for (int i = 1; i < MAX_TAPS; i++) begin
         hist_in[i] = hist_ff[i-1];
      end
   end

   // saturate at the build maximum
   assign fill_in = (int'(fill_ff) == MAX_TAPS) ? fill_ff : CNT_W'(fill_ff + 1'b1);

   always_comb begin
      for (int i = 0; i < MAX_TAPS; i++) begin
         if (i < int'(eff_taps) && fill_in >= eff_taps) begin
            prod_in[i] = hist_in[i] * taps_ff[i];
         end else begin
            prod_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            hist_ff[i] <= '0;
            taps_ff[i] <= '0;
         end
         fill_ff    <= '0;
         s1_ctrl_ff <= '0;
      end else begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            if (load_accept && int'(tap_index) == i) begin
               taps_ff[i] <= coefficient;
            end
         end
         if (sample_accept) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
               hist_ff[i] <= hist_in[i];
            end
            fill_ff <= frame_last ? '0 : fill_in;
         end
         if (advance) begin
            s1_ctrl_ff.valid <= sample_accept;
            s1_ctrl_ff.last  <= frame_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_taps_ff <= eff_taps;
         for (int i = 0; i < MAX_TAPS; i++) begin
            s1_prod_ff[i] <= prod_in[i];
         end
      end
   end

   assign s1_ctrl = s1_ctrl_ff;
   assign s1_taps = s1_taps_ff;
   assign s1_prod = s1_prod_ff;

endmodule

// File: rtl/core/dfir_adder_tree.sv
// ----------------------------------------------------------------------------
// dfir_adder_tree
// Registered group sums of the product row, then the final sum of groups.
// ----------------------------------------------------------------------------
module dfir_adder_tree #(
   parameter int MAX_TAPS = dfir_pkg::DEF_MAX_TAPS,
   parameter int CNT_W    = $clog2(MAX_TAPS + 1),
   parameter int PROD_W   = dfir_pkg::DEF_SAMPLE_BITS + dfir_pkg::COEF_W,
   parameter int SUM_W    = PROD_W + $clog2(MAX_TAPS) + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  dfir_pkg::stage_ctrl_type s1_ctrl,
   input  logic [CNT_W-1:0]         s1_taps,
   input  logic signed [PROD_W-1:0] s1_prod [MAX_TAPS],
   output dfir_pkg::stage_ctrl_type s2_ctrl,
   output logic [CNT_W-1:0]         s2_taps,
   output logic signed [SUM_W-1:0]  s2_sum
);
   import dfir_pkg::*;

   localparam int NUM_GROUPS = (MAX_TAPS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int NUM_TERMS  = NUM_GROUPS * GROUP_SIZE;

   logic signed [SUM_W-1:0] term     [NUM_TERMS];
   logic signed [SUM_W-1:0] group_in [NUM_GROUPS];
   logic signed [SUM_W-1:0] group_ff [NUM_GROUPS];
   stage_ctrl_type          s2_ctrl_ff;
   logic [CNT_W-1:0]        s2_taps_ff;

   for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
      if (k < MAX_TAPS) begin : g_live
         assign term[k] = SUM_W'(s1_prod[k]);
      end else begin : g_pad
         assign term[k] = '0;
      end
   end

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            group_in[g] = group_in[g] + term[g*GROUP_SIZE + j];
         end
      end
   end

   always_comb begin
      s2_sum = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         s2_sum = s2_sum + group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
      end else if (advance) begin
         s2_ctrl_ff <= s1_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_taps_ff <= s1_taps;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_ff[g] <= group_in[g];
         end
      end
   end

   assign s2_ctrl = s2_ctrl_ff;
   assign s2_taps = s2_taps_ff;

endmodule

// File: rtl/core/dfir_out_stage.sv
// ----------------------------------------------------------------------------
// dfir_out_stage
// Result register with the end-of-frame zero padding counter.
// ----------------------------------------------------------------------------
module dfir_out_stage #(
   parameter int MAX_TAPS = dfir_pkg::DEF_MAX_TAPS,
   parameter int CNT_W    = $clog2(MAX_TAPS + 1),
   parameter int SUM_W    = dfir_pkg::DEF_SAMPLE_BITS + dfir_pkg::COEF_W + 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dfir_pkg::stage_ctrl_type            s2_ctrl,
   input  logic [CNT_W-1:0]                    s2_taps,
   input  logic signed [SUM_W-1:0]             s2_sum,
   output logic                                take,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dfir_pkg::OUT_W-1:0]   rsp_filtered,
   output logic                                rsp_frame_end
);
   import dfir_pkg::*;

   localparam int EXT_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;

   logic                    valid_ff;
   logic signed [OUT_W-1:0] filtered_ff;
   logic                    frame_end_ff;
   logic [CNT_W-1:0]        pad_ff;
   logic                    slot_free;
   logic signed [EXT_W-1:0] sum_ext;

   assign slot_free = !valid_ff || rsp_ready;
   assign take      = slot_free && pad_ff == '0;
   assign sum_ext   = EXT_W'(s2_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pad_ff   <= '0;
      end else if (slot_free) begin
         if (pad_ff != '0) begin
            valid_ff <= 1'b1;
            pad_ff   <= CNT_W'(pad_ff - 1'b1);
         end else begin
            valid_ff <= s2_ctrl.valid;
            if (s2_ctrl.valid && s2_ctrl.last) begin
               pad_ff <= s2_taps;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free) begin
         if (pad_ff != '0) begin
            filtered_ff  <= '0;
            frame_end_ff <= (pad_ff == CNT_W'(1));
         end else begin
            filtered_ff  <= sum_ext[OUT_W-1:0];
            frame_end_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_filtered  = filtered_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

// File: rtl/core/direct_form_fir_filter_core.sv
// ----------------------------------------------------------------------------
// direct_form_fir_filter_core
// Streaming direct-form FIR filter with a loadable tap store.
//
//   channel  direction  handshake            carries
//   req      in         req_valid/req_ready  load or sample word
//   rsp      out        rsp_valid/rsp_ready  filtered sum, frame end flag
//   csr      in         APB, pready high     tap count register
//
// One word per cycle when not stalled; a sample's result passes the product
// row, group sums and result register. After a frame's last sample the
// result register emits eff_taps zero words, one per cycle unless stalled,
// while product and group stages hold. Loads give no result. Synchronous
// reset clears the delay line, taps, fill count and all valid flags.
// ----------------------------------------------------------------------------
module direct_form_fir_filter_core #(
   parameter int MAX_TAPS    = dfir_pkg::DEF_MAX_TAPS,
   parameter int SAMPLE_BITS = dfir_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [dfir_pkg::INDEX_W-1:0]        req_tap_index,
   input  logic signed [dfir_pkg::COEF_W-1:0]  req_coefficient,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic                                req_frame_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dfir_pkg::OUT_W-1:0]   rsp_filtered,
   output logic                                rsp_frame_end,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dfir_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dfir_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dfir_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import dfir_pkg::*;

   localparam int CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int PROD_W = SAMPLE_BITS + COEF_W;
   localparam int SUM_W  = PROD_W + $clog2(MAX_TAPS) + 1;

   logic                     accept;
   logic                     load_accept;
   logic                     sample_accept;
   logic                     s1_advance;
   logic                     s2_advance;
   logic                     out_take;
   logic [CNT_W-1:0]         eff_taps;
   stage_ctrl_type           s1_ctrl;
   stage_ctrl_type           s2_ctrl;
   logic [CNT_W-1:0]         s1_taps;
   logic [CNT_W-1:0]         s2_taps;
   logic signed [PROD_W-1:0] s1_prod [MAX_TAPS];
   logic signed [SUM_W-1:0]  s2_sum;

   assign s2_advance    = !s2_ctrl.valid || out_take;
   assign s1_advance    = !s1_ctrl.valid || s2_advance;
   assign req_ready     = s1_advance;
   assign accept        = req_valid && req_ready;
   assign load_accept   = accept && req_command == CMD_LOAD;
   assign sample_accept = accept && req_command == CMD_SAMPLE;

   dfir_csr #(
      .MAX_TAPS (MAX_TAPS),
      .CNT_W    (CNT_W)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .eff_taps    (eff_taps)
   );

   dfir_mac_stage #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .PROD_W      (PROD_W)
   ) u_mac (
      .clock         (clock),
      .reset         (reset),
      .advance       (s1_advance),
      .load_accept   (load_accept),
      .sample_accept (sample_accept),
      .tap_index     (req_tap_index),
      .coefficient   (req_coefficient),
      .sample        (req_sample),
      .frame_last    (req_frame_last),
      .eff_taps      (eff_taps),
      .s1_ctrl       (s1_ctrl),
      .s1_taps       (s1_taps),
      .s1_prod       (s1_prod)
   );

   dfir_adder_tree #(
      .MAX_TAPS (MAX_TAPS),
      .CNT_W    (CNT_W),
      .PROD_W   (PROD_W),
      .SUM_W    (SUM_W)
   ) u_tree (
      .clock   (clock),
      .reset   (reset),
      .advance (s2_advance),
      .s1_ctrl (s1_ctrl),
      .s1_taps (s1_taps),
      .s1_prod (s1_prod),
      .s2_ctrl (s2_ctrl),
      .s2_taps (s2_taps),
      .s2_sum  (s2_sum)
   );

   dfir_out_stage #(
      .MAX_TAPS (MAX_TAPS),
      .CNT_W    (CNT_W),
      .SUM_W    (SUM_W)
   ) u_out (
      .clock         (clock),
      .reset         (reset),
      .s2_ctrl       (s2_ctrl),
      .s2_taps       (s2_taps),
      .s2_sum        (s2_sum),
      .take          (out_take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_filtered  (rsp_filtered),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// File: rtl/core/dfir_checker.sv
// ----------------------------------------------------------------------------
// dfir_checker
// Port-level checks on the filter core, bound to the top level.
// ----------------------------------------------------------------------------
module dfir_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [dfir_pkg::OUT_W-1:0] rsp_filtered,
   input logic                              rsp_frame_end,
   input logic                              csr_pready
);
   import dfir_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered)
                                  && $stable(rsp_frame_end))
      else $error("stalled result word changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // frame end only on a padding word, which is zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_filtered == '0)
      else $error("frame end word not zero");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port not ready");

endmodule

bind direct_form_fir_filter_core dfir_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_filtered  (rsp_filtered),
   .rsp_frame_end (rsp_frame_end),
   .csr_pready    (csr_pready)
);

// File: verif/direct_form_fir_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_form_fir_filter_core_tb
// Drives load and sample words into the FIR core with random idling on both
// channels and rewrites the tap count between phases. Every output word is
// checked against a cycle-free filter computed in the bench: 32-deep delay
// line, tap store, frame fill gating and zero padding after each frame.
// ----------------------------------------------------------------------------
module direct_form_fir_filter_core_tb;
   import dfir_pkg::*;

   localparam int TAPS_MAX   = DEF_MAX_TAPS;
   localparam int SMP_W      = DEF_SAMPLE_BITS;
   localparam int STALL_MAX  = 2000;
   localparam int LONG_HOLD  = 300;
   localparam int SETTLE     = 8;

   typedef struct {
      logic                     command;
      logic [INDEX_W-1:0]       tap_index;
      logic signed [COEF_W-1:0] coefficient;
      logic signed [SMP_W-1:0]  sample;
      logic                     frame_last;
   } fir_word_type;

   typedef struct {
      logic signed [OUT_W-1:0] filtered;
      logic                    frame_end;
   } fir_out_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_command = CMD_LOAD;
   logic [INDEX_W-1:0]       req_tap_index = '0;
   logic signed [COEF_W-1:0] req_coefficient = '0;
   logic signed [SMP_W-1:0]  req_sample = '0;
   logic                     req_frame_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]  rsp_filtered;
   logic                     rsp_frame_end;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_paddr = '0;
   logic [CSR_DATA_W-1:0]    csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   direct_form_fir_filter_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_tap_index  (req_tap_index),
      .req_coefficient(req_coefficient),
      .req_sample     (req_sample),
      .req_frame_last (req_frame_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filtered   (rsp_filtered),
      .rsp_frame_end  (rsp_frame_end),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   fir_word_type  words_to_send[$];
   fir_out_type   outputs_due[$];
   fir_word_type  on_wire;
   fir_out_type   due;

   logic signed [SMP_W-1:0]  delay_line [TAPS_MAX];
   logic signed [COEF_W-1:0] coef_store [TAPS_MAX];
   int                       fill_count;
   logic [TAP_COUNT_W-1:0]   tap_count_reg;

   int words_queued = 0;
   int words_sent   = 0;
   int error_count  = 0;
   int send_gap     = 0;
   int recv_gap     = 0;
   int send_idle_pct = 15;
   int rsp_idle_pct  = 15;
   int long_hold_left = 0;
   bit long_hold_arm  = 1'b0;
   bit long_hold_done = 1'b0;
   int quiet_cycles   = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int taps_in_use();
      if (tap_count_reg == 0) return 1;
      if (tap_count_reg > TAPS_MAX) return TAPS_MAX;
      return int'(tap_count_reg);
   endfunction

   task automatic fir_accept(input fir_word_type w);
      int          n_taps;
      longint      acc;
      fir_out_type o;
      n_taps = taps_in_use();
      if (w.command == CMD_LOAD) begin
         coef_store[w.tap_index] = w.coefficient;
      end else begin
         for (int i = TAPS_MAX - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
         delay_line[0] = w.sample;
         if (fill_count < TAPS_MAX) fill_count++;
         acc = 0;
         if (fill_count >= n_taps) begin
            for (int i = 0; i < n_taps; i++)
               acc += longint'(delay_line[i]) * longint'(coef_store[i]);
         end
         o.filtered  = acc[OUT_W-1:0];
         o.frame_end = 1'b0;
         outputs_due.push_back(o);
         if (w.frame_last) begin
            for (int i = 0; i < n_taps; i++) begin
               o.filtered  = '0;
               o.frame_end = (i + 1 == n_taps);
               outputs_due.push_back(o);
            end
            fill_count = 0;
         end
      end
   endtask

   function automatic logic signed [15:0] pick_value();
      if ($urandom_range(0, 5) == 0) begin
         case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return 16'shffff;
         endcase
      end
      return 16'($urandom);
   endfunction

   task automatic push_word(input logic cmd, input logic [INDEX_W-1:0] idx,
                            input logic signed [COEF_W-1:0] coef,
                            input logic signed [SMP_W-1:0] smp, input logic last);
      fir_word_type w;
      w.command     = cmd;
      w.tap_index   = idx;
      w.coefficient = coef;
      w.sample      = smp;
      w.frame_last  = last;
      words_to_send.push_back(w);
      words_queued++;
   endtask

   task automatic push_load();
      push_word(CMD_LOAD, 5'($urandom), pick_value(), pick_value(), 1'($urandom));
   endtask

   task automatic settle_pipeline();
      while (words_sent != words_queued || outputs_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_tap_count(input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_TAP_COUNT, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tap_count_reg = value[TAP_COUNT_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic build_random_phase(input int n);
      int made;
      int len;
      int r;
      int n_taps;
      made   = 0;
      n_taps = taps_in_use();
      while (made < n) begin
         r = $urandom_range(0, 9);
         if (r < 2) begin
            push_load();
            made++;
         end else begin
            len = (r == 2) ? $urandom_range(1, 4) : n_taps + $urandom_range(0, 10);
            for (int k = 0; k < len && made < n; k++) begin
               if ($urandom_range(0, 15) == 0) begin
                  push_load();
                  made++;
               end
               push_word(CMD_SAMPLE, 5'($urandom), pick_value(), pick_value(), k == len - 1);
               made++;
            end
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_valid) begin
            fir_accept(on_wire);
            words_sent++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (words_to_send.size() == 0) begin
            req_valid <= 1'b0;
         end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            send_gap = $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else begin
            on_wire = words_to_send.pop_front();
            req_command     <= on_wire.command;
            req_tap_index   <= on_wire.tap_index;
            req_coefficient <= on_wire.coefficient;
            req_sample      <= on_wire.sample;
            req_frame_last  <= on_wire.frame_last;
            req_valid       <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outputs_due.size() == 0) begin
               error_count++;
               if (error_count < 20)
                  $display("%0t: unexpected word, expected none, actual filtered %0d end %0b",
                           $time, rsp_filtered, rsp_frame_end);
            end else begin
               due = outputs_due.pop_front();
               if (rsp_filtered !== due.filtered) begin
                  error_count++;
                  if (error_count < 20)
                     $display("%0t: filtered mismatch, expected %0d, actual %0d",
                              $time, due.filtered, rsp_filtered);
               end
               if (rsp_frame_end !== due.frame_end) begin
                  error_count++;
                  if (error_count < 20)
                     $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                              $time, due.frame_end, rsp_frame_end);
               end
            end
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_ready <= 1'b0;
         end else if (long_hold_arm && !long_hold_done && rsp_valid) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            recv_gap = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_MAX) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] plan [9];
      for (int i = 0; i < TAPS_MAX; i++) begin
         delay_line[i] = '0;
         coef_store[i] = '0;
      end
      fill_count    = 0;
      tap_count_reg = TAP_COUNT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // one tap, extremes
      push_word(CMD_LOAD, 5'd0, 16'sh7fff, 16'shffff, 1'b0);
      push_word(CMD_SAMPLE, 5'd0, 16'sh0000, 16'sh8000, 1'b0);
      push_word(CMD_SAMPLE, 5'd0, 16'sh0000, 16'sh7fff, 1'b0);
      push_word(CMD_SAMPLE, 5'd31, 16'sh8000, 16'sh0000, 1'b1);
      push_word(CMD_LOAD, 5'd31, 16'sh8000, 16'sh7fff, 1'b1);
      push_word(CMD_LOAD, 5'd1, 16'sh8000, 16'sh0000, 1'b0);
      push_word(CMD_LOAD, 5'd0, 16'sh8000, 16'sh0000, 1'b0);
      settle_pipeline();
      write_tap_count(32'd2);
      push_word(CMD_SAMPLE, 5'd1, 16'sh7fff, 16'sh8000, 1'b0);
      push_word(CMD_SAMPLE, 5'd1, 16'sh7fff, 16'sh8000, 1'b0);
      push_word(CMD_SAMPLE, 5'd1, 16'sh7fff, 16'sh7fff, 1'b1);
      settle_pipeline();
      // zero count acts as one
      write_tap_count(32'd0);
      push_word(CMD_SAMPLE, 5'd0, 16'sh0000, 16'sh0001, 1'b1);
      settle_pipeline();
      // oversized count acts as the maximum
      write_tap_count(32'd40);
      push_word(CMD_SAMPLE, 5'd0, 16'sh0000, 16'sh8000, 1'b1);
      push_word(CMD_SAMPLE, 5'd0, 16'sh0000, 16'sh7fff, 1'b0);
      push_word(CMD_SAMPLE, 5'd0, 16'sh0000, 16'shffff, 1'b0);
      settle_pipeline();

      // full-scale sums with every tap in use
      write_tap_count(TAPS_MAX);
      for (int i = 0; i < TAPS_MAX; i++)
         push_word(CMD_LOAD, 5'(i), 16'sh8000, 16'($urandom), 1'($urandom));
      for (int k = 0; k < 40; k++)
         push_word(CMD_SAMPLE, 5'($urandom), 16'($urandom),
                   (k < 36 || k[0]) ? 16'sh8000 : 16'sh7fff, k == 35 || k == 39);
      settle_pipeline();

      plan = '{32'd63, 32'd0, 32'd5, 32'd1, 32'd33, 32'($urandom_range(1, 32)),
               32'd24, 32'($urandom_range(1, 32)), 32'd3};
      for (int p = 0; p < 9; p++) begin
         if (p[0])
            write_tap_count({26'($urandom), plan[p][TAP_COUNT_W-1:0]});
         else
            write_tap_count(plan[p]);
         if (p == 8) begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end else begin
            send_idle_pct = $urandom_range(0, 1) ? 0 : $urandom_range(10, 35);
            rsp_idle_pct  = $urandom_range(0, 1) ? 0 : $urandom_range(10, 35);
         end
         long_hold_arm = (p == 0);
         build_random_phase(42);
         settle_pipeline();
      end

      repeat (30) @(posedge clock);
      if (error_count == 0 && outputs_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/core/dfir_pkg.sv
rtl/core/dfir_csr.sv
rtl/core/dfir_mac_stage.sv
rtl/core/dfir_adder_tree.sv
rtl/core/dfir_out_stage.sv
rtl/core/direct_form_fir_filter_core.sv
rtl/core/dfir_checker.sv
verif/direct_form_fir_filter_core_tb.sv
